// File: design/paids_pkg.sv
package paids_pkg;

    localparam int DATA_W        = 32;
    localparam int OP_W          = 3;
    localparam int STAT_W        = 3;
    localparam int DEPTH_DEFAULT = 64;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_SEARCH = 3'd3,
        OP_DUMP   = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_EMPTY    = 3'd1,
        STAT_NOTFOUND = 3'd2,
        STAT_BADPOS   = 3'd3,
        STAT_FULL     = 3'd4
    } status_t;

    // broadcast command to every cell of the chain
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_DELETE,
        CMD_ROTATE
    } cell_cmd_t;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    typedef enum logic {
        MODE_SEARCH,
        MODE_DUMP
    } scan_mode_t;

endpackage

// File: design/positional_array_insert_delete_search.sv
// Ordered list of up to DEPTH signed words kept in a chain of cells, one word
// per cell. Clear, insert, delete and unknown opcodes: the word is accepted
// when start is high and busy is low, its single result shows on the next
// cycle with strobe high, and busy never rises, so a new word can be started
// every cycle. Search and dump rotate the whole ring of cells once, reading
// cell 0 each cycle; busy is high from acceptance until the rotation ends and
// the next word can start once busy falls. Dump emits one result per stored
// entry, in order, on consecutive cycles, with last on the final one. Search
// emits one result at the first match, or not found after the last stored
// entry. Search or dump of an empty list answers without raising busy. Every
// result is on the ports for exactly one cycle and cannot be held off; count
// always shows the number of stored entries after the operation.
module positional_array_insert_delete_search
    import paids_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int IDX_W = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [OP_W-1:0]          opcode,
    input  logic [CNT_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value,
    output logic                     strobe,
    output logic [STAT_W-1:0]        status,
    output logic [IDX_W-1:0]         index,
    output logic signed [DATA_W-1:0] element,
    output logic [CNT_W-1:0]         count,
    output logic                     last
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_ROT = IDX_W'(DEPTH - 1);

    // control state
    state_t            state_reg, state_next;
    scan_mode_t        mode_reg, mode_next;
    logic [IDX_W-1:0]  rot_reg, rot_next;       // rotation step = index at cell 0
    logic              done_reg, done_next;     // search already answered
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              strobe_reg, strobe_next;

    // payload
    logic signed [DATA_W-1:0] key_reg, key_next;
    status_t                  status_reg, status_next;
    logic [IDX_W-1:0]         index_reg, index_next;
    logic signed [DATA_W-1:0] element_reg, element_next;
    logic                     last_reg, last_next;

    cell_cmd_t cmd;
    logic signed [DATA_W-1:0] cell_data [DEPTH];

    // chain of cells; the top cell's right neighbor wraps to cell 0 so the
    // whole chain forms a ring for rotation
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        paids_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk   (clk),
            .cmd   (cmd),
            .pos   (position),
            .value (value),
            .left  ((i == 0) ? value : cell_data[(i == 0) ? 0 : i - 1]),
            .right (cell_data[(i + 1) % DEPTH]),
            .data  (cell_data[i])
        );
    end

    logic [CNT_W-1:0] rot_ext;
    logic             in_range;
    logic             at_last_entry;

    assign rot_ext       = CNT_W'(rot_reg);
    assign in_range      = rot_ext < count_reg;
    assign at_last_entry = (rot_ext + CNT_W'(1)) == count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mode_reg   <= MODE_SEARCH;
            rot_reg    <= '0;
            done_reg   <= 1'b0;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            rot_reg    <= rot_next;
            done_reg   <= done_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        status_reg  <= status_next;
        index_reg   <= index_next;
        element_reg <= element_next;
        last_reg    <= last_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        rot_next     = rot_reg;
        done_next    = done_reg;
        count_next   = count_reg;
        strobe_next  = 1'b0;
        key_next     = key_reg;
        status_next  = STAT_OK;
        index_next   = '0;
        element_next = '0;
        last_next    = 1'b1;
        cmd          = CMD_HOLD;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    strobe_next = 1'b1;
                    unique case (opcode)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_INSERT:
                        begin
                            // full takes precedence over a bad position
                            if (count_reg >= FULL_CNT)
                            begin
                                status_next = STAT_FULL;
                            end
                            else if (position > count_reg)
                            begin
                                status_next = STAT_BADPOS;
                            end
                            else
                            begin
                                cmd        = CMD_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else if (position >= count_reg)
                            begin
                                status_next = STAT_BADPOS;
                            end
                            else
                            begin
                                cmd        = CMD_DELETE;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_NOTFOUND;
                            end
                            else
                            begin
                                strobe_next = 1'b0;
                                key_next    = value;
                                mode_next   = MODE_SEARCH;
                                state_next  = S_SCAN;
                                rot_next    = '0;
                                done_next   = 1'b0;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                strobe_next = 1'b0;
                                mode_next   = MODE_DUMP;
                                state_next  = S_SCAN;
                                rot_next    = '0;
                                done_next   = 1'b0;
                            end
                        end
                        default:
                        begin
                            // unused opcodes: plain ok
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // one full turn of the ring restores the original order
                cmd      = CMD_ROTATE;
                rot_next = rot_reg + IDX_W'(1);
                if (mode_reg == MODE_DUMP)
                begin
                    if (in_range)
                    begin
                        strobe_next  = 1'b1;
                        index_next   = rot_reg;
                        element_next = cell_data[0];
                        last_next    = at_last_entry;
                    end
                end
                else if (!done_reg && in_range)
                begin
                    if (cell_data[0] == key_reg)
                    begin
                        strobe_next = 1'b1;
                        index_next  = rot_reg;
                        done_next   = 1'b1;
                    end
                    else if (at_last_entry)
                    begin
                        strobe_next = 1'b1;
                        status_next = STAT_NOTFOUND;
                        done_next   = 1'b1;
                    end
                end
                if (rot_reg == LAST_ROT)
                begin
                    state_next = S_IDLE;
                    rot_next   = '0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy    = (state_reg != S_IDLE);
    assign strobe  = strobe_reg;
    assign status  = status_reg;
    assign index   = index_reg;
    assign element = element_reg;
    assign count   = count_reg;
    assign last    = last_reg;

endmodule

// File: design/paids_cell.sv
module paids_cell
    import paids_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
)
(
    input  logic                     clk,
    input  cell_cmd_t                cmd,
    input  logic [CNT_W-1:0]         pos,
    input  logic signed [DATA_W-1:0] value,
    input  logic signed [DATA_W-1:0] left,
    input  logic signed [DATA_W-1:0] right,
    output logic signed [DATA_W-1:0] data
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (cmd)
            CMD_INSERT:
            begin
                if (pos == MY_IDX)
                begin
                    data_next = value;
                end
                else if (pos < MY_IDX)
                begin
                    data_next = left;
                end
            end
            CMD_DELETE:
            begin
                if (pos <= MY_IDX)
                begin
                    data_next = right;
                end
            end
            CMD_ROTATE:
            begin
                data_next = right;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

// Self-checking bench for the positional list block.
// Words are driven on the falling edge; acceptance and result strobes are
// sampled on the rising edge. A shadow copy of the list predicts every result
// word, and the monitor checks the strobed words in order against it.
module testbench;
    import paids_pkg::*;

    localparam int LIST_DEPTH     = DEPTH_DEFAULT;
    localparam int IDX_BITS       = $clog2(LIST_DEPTH);
    localparam int CNT_BITS       = $clog2(LIST_DEPTH + 1);
    localparam int DIRECTED_ROWS  = 25;
    localparam int RANDOM_WORDS   = 64;
    localparam int WATCHDOG_LIMIT = 1000;

    // opcodes outside the defined set; the block treats them as no-ops
    localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

    localparam logic [DATA_W-1:0]   VAL_MIN  = 32'h8000_0000;
    localparam logic [DATA_W-1:0]   VAL_MAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0]   VAL_ONES = 32'hFFFF_FFFF;
    localparam logic [CNT_BITS-1:0] POS_ALL  = 7'h7F;
    localparam logic [CNT_BITS-1:0] POS_CAP  = 7'd64;

    // one strobed result word
    typedef struct packed {
        status_t             status;
        logic [IDX_BITS-1:0] index;
        logic [DATA_W-1:0]   element;
        logic [CNT_BITS-1:0] count;
        logic                last;
    } reply_t;

    // one row of the directed table; typed rows carry their own expected word
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [CNT_BITS-1:0] pos;
        logic [DATA_W-1:0]   val;
        logic                typed;
        status_t             st;
        logic [IDX_BITS-1:0] idx;
        logic [CNT_BITS-1:0] cnt;
    } stim_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [OP_W-1:0]          opcode;
    logic [CNT_BITS-1:0]      position;
    logic signed [DATA_W-1:0] value;
    logic                     strobe;
    logic [STAT_W-1:0]        status;
    logic [IDX_BITS-1:0]      index;
    logic signed [DATA_W-1:0] element;
    logic [CNT_BITS-1:0]      count;
    logic                     last;

    // shadow of the list contents and the result words still owed
    logic [DATA_W-1:0] shadow_list [LIST_DEPTH];
    int                shadow_count;
    reply_t            pending_replies [$];

    stim_row_t directed_rows [DIRECTED_ROWS];
    int        mismatches;
    int        quiet_cycles;
    int        burst_left;

    positional_array_insert_delete_search dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .opcode   (opcode),
        .position (position),
        .value    (value),
        .strobe   (strobe),
        .status   (status),
        .index    (index),
        .element  (element),
        .count    (count),
        .last     (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("%0t ns: %s mismatch, got %0h want %0h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic reply_t make_reply(input status_t st, input logic [IDX_BITS-1:0] idx,
                                          input logic [CNT_BITS-1:0] cnt);
        reply_t r;
        r = '0;
        r.status = st;
        r.index  = idx;
        r.count  = cnt;
        r.last   = 1'b1;
        return r;
    endfunction

    // count field always shows the list size after the operation
    task automatic push_reply(input status_t st, input int idx, input logic [DATA_W-1:0] elem,
                              input logic lst);
        reply_t r;
        r.status  = st;
        r.index   = IDX_BITS'(idx);
        r.element = elem;
        r.count   = CNT_BITS'(shadow_count);
        r.last    = lst;
        pending_replies.push_back(r);
    endtask

    // Predictor: applies one accepted word to the shadow list and queues
    // the result words it owes.
    task automatic apply_list_op(input logic [OP_W-1:0] op, input logic [CNT_BITS-1:0] pos,
                                 input logic [DATA_W-1:0] val);
        int i;
        bit hit;
        hit = 1'b0;
        case (op)
            OP_CLEAR:
            begin
                shadow_count = 0;
                push_reply(STAT_OK, 0, '0, 1'b1);
            end
            OP_INSERT:
            begin
                // full wins over a bad position
                if (shadow_count >= LIST_DEPTH)
                    push_reply(STAT_FULL, 0, '0, 1'b1);
                else if (pos > shadow_count)
                    push_reply(STAT_BADPOS, 0, '0, 1'b1);
                else
                begin
                    for (i = shadow_count; i > pos; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[pos] = val;
                    shadow_count++;
                    push_reply(STAT_OK, 0, '0, 1'b1);
                end
            end
            OP_DELETE:
            begin
                if (shadow_count == 0)
                    push_reply(STAT_EMPTY, 0, '0, 1'b1);
                else if (pos >= shadow_count)
                    push_reply(STAT_BADPOS, 0, '0, 1'b1);
                else
                begin
                    for (i = pos; i + 1 < shadow_count; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_count--;
                    push_reply(STAT_OK, 0, '0, 1'b1);
                end
            end
            OP_SEARCH:
            begin
                // lowest matching index only
                for (i = 0; i < shadow_count; i++)
                begin
                    if (!hit && shadow_list[i] == val)
                    begin
                        hit = 1'b1;
                        push_reply(STAT_OK, i, '0, 1'b1);
                    end
                end
                if (!hit)
                    push_reply(STAT_NOTFOUND, 0, '0, 1'b1);
            end
            OP_DUMP:
            begin
                if (shadow_count == 0)
                    push_reply(STAT_EMPTY, 0, '0, 1'b1);
                else
                    for (i = 0; i < shadow_count; i++)
                        push_reply(STAT_OK, i, shadow_list[i], i + 1 == shadow_count);
            end
            default:
                push_reply(STAT_OK, 0, '0, 1'b1);
        endcase
    endtask

    // Called at a falling edge. Holds start high until the block takes the
    // word, predicts at that rising edge, returns at the next falling edge.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [CNT_BITS-1:0] pos,
                             input logic [DATA_W-1:0] val, input logic typed,
                             input reply_t typed_reply);
        start    <= 1'b1;
        opcode   <= op;
        position <= pos;
        value    <= val;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        apply_list_op(op, pos, val);
        if (typed)
        begin
            // table value replaces the predicted single word
            void'(pending_replies.pop_back());
            pending_replies.push_back(typed_reply);
        end
        @(negedge clk);
    endtask

    // Sender gap: mostly none or short, a few long, with gap-free bursts.
    task automatic pause_sender();
        int r;
        int n;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            burst_left = 12;
            n = 0;
        end
        else if (r < 55)
            n = 0;
        else if (r < 90)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(8, 40);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // Stop sending until every owed word has come back.
    task automatic drain_replies();
        start <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Mix of random words, small values that repeat (so searches hit
    // duplicates), and the two signed extremes.
    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return DATA_W'($urandom_range(0, 7) - 4);
        else if (r < 40)
            return ($urandom_range(0, 1) != 0) ? VAL_MAX : VAL_MIN;
        return $urandom();
    endfunction

    function automatic logic [DATA_W-1:0] pick_search_value();
        if (shadow_count > 0 && $urandom_range(0, 99) < 65)
            return shadow_list[$urandom_range(0, shadow_count - 1)];
        return pick_value();
    endfunction

    // Result monitor: every strobed word must match the oldest owed one.
    task automatic check_reply();
        reply_t want;
        if (pending_replies.size() == 0)
        begin
            report_mismatch("unexpected word, status", DATA_W'(status), '0);
            return;
        end
        want = pending_replies.pop_front();
        if (status !== want.status)
            report_mismatch("status", DATA_W'(status), DATA_W'(want.status));
        if (index !== want.index)
            report_mismatch("index", DATA_W'(index), DATA_W'(want.index));
        if (element !== want.element)
            report_mismatch("element", element, want.element);
        if (count !== want.count)
            report_mismatch("count", DATA_W'(count), DATA_W'(want.count));
        if (last !== want.last)
            report_mismatch("last", DATA_W'(last), DATA_W'(want.last));
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            // watchdog resets on any word moving in either direction
            if ((start && busy === 1'b0) || strobe === 1'b1)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (strobe === 1'b1)
                check_reply();
            else if (strobe !== 1'b0)
                report_mismatch("strobe unknown", '0, '0);
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("FAIL positional_array_insert_delete_search");
        $finish;
    end

    initial
    begin
        int          i;
        int          k;
        int          r;
        int          ins_end;
        int          del_end;
        bit          grow;
        logic [OP_W-1:0]     op;
        logic [CNT_BITS-1:0] pos;
        logic [DATA_W-1:0]   val;

        mismatches   = 0;
        quiet_cycles = 0;
        burst_left   = 0;
        shadow_count = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        opcode       = OP_CLEAR;
        position     = '0;
        value        = '0;

        // Directed table. Typed rows: empty list after reset, error codes, inserts,
        // first-match search, spare opcodes, clear. The rest go through the predictor.
        directed_rows = '{
            '{OP_DUMP,     7'd0,    32'd0,     1'b1, STAT_EMPTY,    6'd0, 7'd0},
            '{OP_DELETE,   7'd0,    32'd0,     1'b1, STAT_EMPTY,    6'd0, 7'd0},
            '{OP_SEARCH,   7'd0,    32'd0,     1'b1, STAT_NOTFOUND, 6'd0, 7'd0},
            '{OP_INSERT,   7'd1,    32'd5,     1'b1, STAT_BADPOS,   6'd0, 7'd0},
            '{OP_INSERT,   7'd0,    VAL_MIN,   1'b1, STAT_OK,       6'd0, 7'd1},
            '{OP_INSERT,   7'd1,    VAL_MAX,   1'b1, STAT_OK,       6'd0, 7'd2},
            '{OP_INSERT,   7'd0,    VAL_ONES,  1'b1, STAT_OK,       6'd0, 7'd3},
            '{OP_INSERT,   7'd1,    32'd0,     1'b0, STAT_OK,       6'd0, 7'd0},
            '{OP_INSERT,   7'd4,    VAL_ONES,  1'b0, STAT_OK,       6'd0, 7'd0},
            '{OP_SEARCH,   7'd0,    VAL_ONES,  1'b1, STAT_OK,       6'd0, 7'd5},
            '{OP_SEARCH,   7'd0,    VAL_MAX,   1'b0, STAT_OK,       6'd0, 7'd0},
            '{OP_SEARCH,   POS_ALL, 32'd12345, 1'b1, STAT_NOTFOUND, 6'd0, 7'd5},
            '{OP_DUMP,     7'd0,    32'd0,     1'b0, STAT_OK,       6'd0, 7'd0},
            '{OP_DELETE,   7'd5,    32'd0,     1'b1, STAT_BADPOS,   6'd0, 7'd5},
            '{OP_DELETE,   POS_ALL, VAL_ONES,  1'b1, STAT_BADPOS,   6'd0, 7'd5},
            '{OP_INSERT,   POS_CAP, 32'd7,     1'b1, STAT_BADPOS,   6'd0, 7'd5},
            '{OP_INSERT,   7'd6,    32'd7,     1'b1, STAT_BADPOS,   6'd0, 7'd5},
            '{OP_DELETE,   7'd0,    32'd0,     1'b1, STAT_OK,       6'd0, 7'd4},
            '{OP_DELETE,   7'd3,    32'd0,     1'b0, STAT_OK,       6'd0, 7'd0},
            '{OP_SPARE_LO, POS_ALL, VAL_ONES,  1'b1, STAT_OK,       6'd0, 7'd3},
            '{OP_SPARE_MID, 7'd0,   32'd0,     1'b1, STAT_OK,       6'd0, 7'd3},
            '{OP_SPARE_HI, 7'd2,    VAL_MIN,   1'b1, STAT_OK,       6'd0, 7'd3},
            '{OP_SEARCH,   7'd0,    VAL_MIN,   1'b0, STAT_OK,       6'd0, 7'd0},
            '{OP_CLEAR,    7'd0,    32'd0,     1'b1, STAT_OK,       6'd0, 7'd0},
            '{OP_DUMP,     7'd0,    32'd0,     1'b1, STAT_EMPTY,    6'd0, 7'd0}
        };

        // async reset held low, then released on a falling edge
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_word(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].val,
                      directed_rows[i].typed,
                      make_reply(directed_rows[i].st, directed_rows[i].idx,
                                 directed_rows[i].cnt));
            pause_sender();
        end
        drain_replies();

        // Fill to capacity at random legal positions, then hit the full
        // list: insert is refused even at a bad position, dump covers
        // the top index.
        while (shadow_count < LIST_DEPTH)
        begin
            send_word(OP_INSERT, CNT_BITS'($urandom_range(0, shadow_count)), pick_value(),
                      1'b0, '0);
            pause_sender();
        end
        send_word(OP_INSERT, POS_CAP, VAL_MAX, 1'b1, make_reply(STAT_FULL, '0, POS_CAP));
        send_word(OP_INSERT, POS_ALL, VAL_MIN, 1'b1, make_reply(STAT_FULL, '0, POS_CAP));
        send_word(OP_INSERT, 7'd0, 32'd0, 1'b1, make_reply(STAT_FULL, '0, POS_CAP));
        send_word(OP_SEARCH, 7'd0, shadow_list[LIST_DEPTH-1], 1'b0, '0);
        pause_sender();
        send_word(OP_DUMP, 7'd0, 32'd0, 1'b0, '0);
        send_word(OP_DELETE, POS_CAP, 32'd0, 1'b1, make_reply(STAT_BADPOS, '0, POS_CAP));
        send_word(OP_DELETE, 7'(LIST_DEPTH - 1), 32'd0, 1'b0, '0);
        send_word(OP_INSERT, 7'(LIST_DEPTH - 1), VAL_ONES, 1'b0, '0);
        pause_sender();

        // Random phase. The list drifts down then up in stretches of 40 words
        // so it visits both near-empty and near-full states.
        grow = 1'b1;
        for (k = 0; k < RANDOM_WORDS; k++)
        begin
            if (k % 40 == 0)
                grow = !grow;
            ins_end = 5 + (grow ? 47 : 17);
            del_end = ins_end + (grow ? 17 : 47);
            r = $urandom_range(0, 99);
            if (r < 2)
                op = OP_CLEAR;
            else if (r < 5)
                op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            else if (r < ins_end)
                op = OP_INSERT;
            else if (r < del_end)
                op = OP_DELETE;
            else if (r < del_end + 22)
                op = OP_SEARCH;
            else
                op = OP_DUMP;

            // mostly legal positions, sometimes anything the port carries
            r = $urandom_range(0, 99);
            if (op == OP_INSERT && r < 85)
                pos = CNT_BITS'($urandom_range(0, shadow_count));
            else if (op == OP_DELETE && shadow_count > 0 && r < 85)
                pos = CNT_BITS'($urandom_range(0, shadow_count - 1));
            else
                pos = CNT_BITS'($urandom_range(0, 127));

            val = (op == OP_SEARCH) ? pick_search_value() : pick_value();
            send_word(op, pos, val, 1'b0, '0);
            if ($urandom_range(0, 24) == 0)
                drain_replies();
            else
                pause_sender();
        end

        // wait out the owed words, then a full rotation for strays
        drain_replies();
        repeat (LIST_DEPTH + 8) @(posedge clk);

        if (mismatches == 0)
            $display("PASS positional_array_insert_delete_search");
        else
            $display("FAIL positional_array_insert_delete_search");
        $finish;
    end

endmodule
